@@ rtl/indexed_list_insert_delete_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the indexed list
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_INSERT_DELETE_ASSERT_SVH
`define INDEXED_LIST_INSERT_DELETE_ASSERT_SVH

// consequent in the same cycle
`define ILID_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("indexed list assertion failed");

// consequent in the next cycle
`define ILID_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("indexed list assertion failed");

`endif

@@ rtl/ilid_pkg.sv @@
// ----------------------------------------------------------------------------
// ilid_pkg
// Types and codes shared by the indexed list controller, datapath and top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ilid_pkg;

    localparam int POS_W = 16;
    localparam int VAL_W = 32;

    typedef enum logic [2:0] {
        OP_READ       = 3'd0,
        OP_INS_HEAD   = 3'd1,
        OP_APPEND     = 3'd2,
        OP_INS_BEFORE = 3'd3,
        OP_DELETE     = 3'd4
    } op_t;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    localparam logic signed [VAL_W-1:0] READ_MISS = -32'sd1;

    typedef enum logic [1:0] {
        K_READ,
        K_INSERT,
        K_DELETE,
        K_REJECT
    } kind_t;

    typedef struct packed {
        logic [2:0]              operation;
        logic signed [POS_W-1:0] position;
        logic signed [VAL_W-1:0] item_value;
    } req_item_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] read_value;
        logic [1:0]              status;
        logic [6:0]              length_now;
    } rsp_item_t;

    typedef struct packed {
        logic load;
        logic decide;
        logic rd_item;
        logic shift;
        logic put;
        logic cap_read;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  shift_needed;
        logic  last_read;
        logic  out_free;
    } dp_stat_t;

endpackage

@@ rtl/ilid_ram.sv @@
// ----------------------------------------------------------------------------
// ilid_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ilid_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/ilid_datapath.sv @@
// ----------------------------------------------------------------------------
// ilid_datapath
// Element store, length counter, request decode, shift pointers and the
// result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ilid_datapath #(
    parameter int CAPACITY = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ilid_pkg::req_item_t   req,
    input  ilid_pkg::dp_cmd_t     cmd,
    output ilid_pkg::dp_stat_t    stat,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output ilid_pkg::rsp_item_t   rsp
);

    import ilid_pkg::*;

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    req_item_t               item_reg;
    logic [CW-1:0]           count_reg;
    logic [CW-1:0]           count_next;
    logic [AW-1:0]           ptr_reg;
    logic [AW-1:0]           prev_reg;
    logic                    wpend_reg;
    logic signed [VAL_W-1:0] value_reg;
    logic                    rsp_valid_reg;
    rsp_item_t               rsp_reg;

    logic                    pos_neg;
    logic [CMPW-1:0]         pos_ext;
    logic [CMPW-1:0]         cnt_ext;
    logic                    in_range;
    logic                    past_end;
    logic                    full;
    kind_t                   kind;
    logic [1:0]              status;
    logic [CW-1:0]           where_c;
    logic                    shift_needed;
    logic [AW-1:0]           end_ptr;
    logic [AW-1:0]           start_ptr;

    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [VAL_W-1:0]        ram_wdata;
    logic                    ram_re;
    logic [AW-1:0]           ram_raddr;
    logic [VAL_W-1:0]        ram_rdata;

    assign pos_neg  = item_reg.position[POS_W-1];
    assign pos_ext  = CMPW'($unsigned(item_reg.position));
    assign cnt_ext  = CMPW'(count_reg);
    assign in_range = !pos_neg && (pos_ext < cnt_ext);
    assign past_end = !pos_neg && (pos_ext > cnt_ext);
    assign full     = (count_reg == CW'(CAPACITY));

    always_comb
    begin
        kind    = K_REJECT;
        status  = ST_INVALID;
        where_c = '0;
        case (item_reg.operation)
            OP_READ:
            begin
                if (in_range)
                begin
                    kind   = K_READ;
                    status = ST_DONE;
                end
            end
            OP_INS_HEAD:
            begin
                status = full ? ST_FULL : ST_DONE;
                kind   = full ? K_REJECT : K_INSERT;
            end
            OP_APPEND:
            begin
                status  = full ? ST_FULL : ST_DONE;
                kind    = full ? K_REJECT : K_INSERT;
                where_c = count_reg;
            end
            OP_INS_BEFORE:
            begin
                if (!past_end)
                begin
                    status  = full ? ST_FULL : ST_DONE;
                    kind    = full ? K_REJECT : K_INSERT;
                    where_c = pos_neg ? '0 : pos_ext[CW-1:0];
                end
            end
            OP_DELETE:
            begin
                if (in_range)
                begin
                    kind    = K_DELETE;
                    status  = ST_DONE;
                    where_c = pos_ext[CW-1:0];
                end
            end
            default:
            begin
                kind   = K_REJECT;
                status = ST_INVALID;
            end
        endcase
    end

    always_comb
    begin
        case (kind)
            K_INSERT: shift_needed = (where_c != count_reg);
            K_DELETE: shift_needed = (({1'b0, where_c} + (CW+1)'(1)) != {1'b0, count_reg});
            default:  shift_needed = 1'b0;
        endcase
    end

    always_comb
    begin
        if (kind == K_INSERT)
        begin
            start_ptr = AW'(count_reg - CW'(1));
            end_ptr   = where_c[AW-1:0];
        end
        else
        begin
            start_ptr = AW'(where_c + CW'(1));
            end_ptr   = AW'(count_reg - CW'(1));
        end
    end

    assign stat.kind         = kind;
    assign stat.shift_needed = shift_needed;
    assign stat.last_read    = (ptr_reg == end_ptr);
    assign stat.out_free     = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        ram_re    = cmd.rd_item || cmd.shift;
        ram_raddr = cmd.rd_item ? pos_ext[AW-1:0] : ptr_reg;
        ram_we    = wpend_reg || cmd.put;
        if (wpend_reg)
        begin
            ram_waddr = (kind == K_INSERT) ? (prev_reg + AW'(1)) : (prev_reg - AW'(1));
            ram_wdata = ram_rdata;
        end
        else
        begin
            ram_waddr = where_c[AW-1:0];
            ram_wdata = item_reg.item_value;
        end
    end

    ilid_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        case (kind)
            K_INSERT: count_next = count_reg + CW'(1);
            K_DELETE: count_next = count_reg - CW'(1);
            default:  count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            wpend_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            wpend_reg <= cmd.shift;
            if (cmd.emit)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= req;
        end
        if (cmd.decide)
        begin
            ptr_reg <= start_ptr;
        end
        else if (cmd.shift)
        begin
            ptr_reg  <= (kind == K_INSERT) ? (ptr_reg - AW'(1)) : (ptr_reg + AW'(1));
            prev_reg <= ptr_reg;
        end
        if (cmd.cap_read)
        begin
            value_reg <= ram_rdata;
        end
        if (cmd.emit)
        begin
            if (kind == K_READ)
            begin
                rsp_reg.read_value <= value_reg;
            end
            else if (item_reg.operation == OP_READ)
            begin
                rsp_reg.read_value <= READ_MISS;
            end
            else
            begin
                rsp_reg.read_value <= '0;
            end
            rsp_reg.status     <= status;
            rsp_reg.length_now <= 7'(count_next);
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

@@ rtl/ilid_controller.sv @@
// ----------------------------------------------------------------------------
// ilid_controller
// Sequencer for one request at a time: decode, element moves, final write
// and result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ilid_controller (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  ilid_pkg::dp_stat_t stat,
    output ilid_pkg::dp_cmd_t  cmd
);

    import ilid_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_RDWAIT,
        S_SHIFT,
        S_DRAIN,
        S_PUT,
        S_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.load = req_valid;
                if (req_valid)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                case (stat.kind)
                    K_READ:
                    begin
                        cmd.rd_item = 1'b1;
                        state_next  = S_RDWAIT;
                    end
                    K_INSERT: state_next = stat.shift_needed ? S_SHIFT : S_PUT;
                    K_DELETE: state_next = stat.shift_needed ? S_SHIFT : S_EMIT;
                    default:  state_next = S_EMIT;
                endcase
            end
            S_RDWAIT:
            begin
                cmd.cap_read = 1'b1;
                state_next   = S_EMIT;
            end
            S_SHIFT:
            begin
                cmd.shift = 1'b1;
                if (stat.last_read)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = (stat.kind == K_INSERT) ? S_PUT : S_EMIT;
            end
            S_PUT:
            begin
                cmd.put    = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);

endmodule

@@ rtl/indexed_list_insert_delete.sv @@
// ----------------------------------------------------------------------------
// indexed_list_insert_delete
// Ordered list of up to CAPACITY signed 32-bit values held in a single
// write, single read RAM. One request is in flight at a time; the result
// register lets the next request be taken while a result waits. Elements
// move only when an insert or delete is not at the tail; each moved element
// is read from the RAM and written back one place over, and a drain step
// follows the last move. The store needs no clearing after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module indexed_list_insert_delete #(
    parameter int CAPACITY = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  ilid_pkg::req_item_t req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output ilid_pkg::rsp_item_t rsp
);

    import ilid_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    ilid_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ilid_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

`include "indexed_list_insert_delete_assert.svh"

    `ILID_ASSERT_NEXT(a_busy_after_accept, cmd.load, !req_ready)
    `ILID_ASSERT_SAME(a_length_bound, rsp_valid, rsp.length_now <= CAPACITY)
    `ILID_ASSERT_SAME(a_full_length, rsp_valid && (rsp.status == ST_FULL),
        rsp.length_now == 7'(CAPACITY))
    `ILID_ASSERT_SAME(a_emit_when_free, cmd.emit, !rsp_valid || rsp_ready)

endmodule

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the indexed list. Requests are driven with bursty
// pacing against a stalling response side. A scoreboard keeps its own copy
// of the list, predicts each response, and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import ilid_pkg::*;

    localparam int CAP = 64;
    localparam int RANDOM_ITEMS = 825;
    localparam int QUIET_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 100;

    localparam logic [2:0] OP_BAD_LO  = 3'd5;
    localparam logic [2:0] OP_BAD_MID = 3'd6;
    localparam logic [2:0] OP_BAD_HI  = 3'd7;

    typedef enum int {
        FILL_PHASE,
        DRAIN_PHASE,
        MIXED_PHASE
    } phase_t;

    class list_tracker;
        logic [VAL_W-1:0] cells [CAP];
        int               count;
        rsp_item_t        expected_rsp [$];
        int               errors;

        function new();
            count = 0;
            errors = 0;
        endfunction

        function void put_at(int where, logic [VAL_W-1:0] value);
            for (int i = count; i > where; i--)
                cells[i] = cells[i - 1];
            cells[where] = value;
            count++;
        endfunction

        function void take_request(req_item_t r);
            rsp_item_t e;
            int        pos;
            bit        in_range;
            bit        full;
            pos = r.position;
            in_range = (pos >= 0) && (pos < count);
            full = count >= CAP;
            e.read_value = '0;
            e.status = ST_DONE;
            case (r.operation)
                OP_READ:
                    if (in_range)
                        e.read_value = cells[pos];
                    else
                    begin
                        e.read_value = READ_MISS;
                        e.status = ST_INVALID;
                    end
                OP_INS_HEAD:
                    if (full)
                        e.status = ST_FULL;
                    else
                        put_at(0, r.item_value);
                OP_APPEND:
                    if (full)
                        e.status = ST_FULL;
                    else
                        put_at(count, r.item_value);
                OP_INS_BEFORE:
                    if (pos >= 0 && pos > count)
                        e.status = ST_INVALID;
                    else if (full)
                        e.status = ST_FULL;
                    else
                        put_at((pos < 0) ? 0 : pos, r.item_value);
                OP_DELETE:
                    if (in_range)
                    begin
                        for (int i = pos; i + 1 < count; i++)
                            cells[i] = cells[i + 1];
                        count--;
                    end
                    else
                        e.status = ST_INVALID;
                default:
                    e.status = ST_INVALID;
            endcase
            e.length_now = count[6:0];
            expected_rsp.push_back(e);
        endfunction

        function void check_result(rsp_item_t got);
            rsp_item_t e;
            if (expected_rsp.size() == 0)
            begin
                $error("unexpected result: read_value %0d status %0d length_now %0d",
                       got.read_value, got.status, got.length_now);
                errors++;
                return;
            end
            e = expected_rsp.pop_front();
            if (got.read_value !== e.read_value)
            begin
                $error("read_value: expected %0d, got %0d", e.read_value, got.read_value);
                errors++;
            end
            if (got.status !== e.status)
            begin
                $error("status: expected %0d, got %0d", e.status, got.status);
                errors++;
            end
            if (got.length_now !== e.length_now)
            begin
                $error("length_now: expected %0d, got %0d", e.length_now, got.length_now);
                errors++;
            end
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_ready;
    req_item_t req;
    logic      rsp_valid;
    logic      rsp_ready;
    rsp_item_t rsp;

    list_tracker tracker;
    int          burst_left;
    int          quiet_cycles = 0;

    indexed_list_insert_delete #(
        .CAPACITY (CAP)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
                tracker.check_result(rsp);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // stall pattern: always ready, coin flip, rare stalls, long stalls
    initial
    begin
        int mode;
        int span;
        rsp_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(10, 80);
            repeat (span)
            begin
                @(negedge clk);
                case (mode)
                    0: rsp_ready = 1'b1;
                    1: rsp_ready = 1'($urandom_range(0, 1));
                    2: rsp_ready = ($urandom_range(0, 7) != 0);
                    default: rsp_ready = ($urandom_range(0, 15) == 0);
                endcase
            end
        end
    end

    task automatic send_item(input req_item_t item);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                @(negedge clk);
                req_valid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        req_valid = 1'b1;
        req = item;
        do
            @(posedge clk);
        while (!req_ready);
        tracker.take_request(item);
    endtask

    task automatic send_op(input logic [2:0] op, input int pos, input logic [31:0] value);
        req_item_t item;
        item.operation = op;
        item.position = pos[POS_W-1:0];
        item.item_value = value;
        send_item(item);
    endtask

    function automatic logic signed [POS_W-1:0] pick_position(int len, bit allow_end);
        int roll;
        int upper;
        roll = $urandom_range(0, 9);
        upper = allow_end ? len : len - 1;
        case (roll)
            0: return POS_W'(-$urandom_range(1, 32768));
            1: return POS_W'(len + $urandom_range(allow_end ? 1 : 0, 40));
            2:
                case ($urandom_range(0, 2))
                    0: return 16'sh7fff;
                    1: return 16'sh8000;
                    default: return POS_W'($urandom);
                endcase
            default:
                if (upper < 0)
                    return POS_W'(len);
                else
                    return POS_W'($urandom_range(upper, 0));
        endcase
    endfunction

    function automatic req_item_t random_request(phase_t phase, int len);
        req_item_t item;
        int        roll;
        int        head_cut;
        int        tail_cut;
        int        before_cut;
        int        read_cut;
        item.item_value = $urandom;
        item.position = POS_W'($urandom);
        if ($urandom_range(0, 9) == 0)
        begin
            item.operation = 3'($urandom_range(0, 7));
            return item;
        end
        case (phase)
            FILL_PHASE:
            begin
                head_cut = 20; tail_cut = 40; before_cut = 75; read_cut = 88;
            end
            DRAIN_PHASE:
            begin
                head_cut = 8; tail_cut = 16; before_cut = 26; read_cut = 45;
            end
            default:
            begin
                head_cut = 15; tail_cut = 30; before_cut = 50; read_cut = 75;
            end
        endcase
        roll = $urandom_range(0, 99);
        if (roll < head_cut)
            item.operation = OP_INS_HEAD;
        else if (roll < tail_cut)
            item.operation = OP_APPEND;
        else if (roll < before_cut)
        begin
            item.operation = OP_INS_BEFORE;
            item.position = pick_position(len, 1'b1);
        end
        else if (roll < read_cut)
        begin
            item.operation = OP_READ;
            item.position = pick_position(len, 1'b0);
        end
        else
        begin
            item.operation = OP_DELETE;
            item.position = pick_position(len, 1'b0);
        end
        return item;
    endfunction

    initial
    begin
        phase_t phase;
        int     phase_left;
        tracker = new();
        burst_left = 0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_op(OP_READ, 0, 32'h0);
        send_op(OP_DELETE, 0, 32'h0);
        send_op(OP_READ, -32768, 32'hffff_ffff);
        send_op(OP_INS_BEFORE, 1, 32'h1234_5678);
        send_op(OP_INS_BEFORE, 32767, 32'h1234_5678);
        send_op(OP_INS_BEFORE, 0, 32'h7fff_ffff);
        send_op(OP_INS_HEAD, 0, 32'h8000_0000);
        send_op(OP_APPEND, 0, 32'hffff_ffff);
        send_op(OP_INS_BEFORE, -1, 32'h0);
        send_op(OP_INS_BEFORE, 4, 32'h5a5a_5a5a);
        send_op(OP_INS_BEFORE, 2, 32'ha5a5_a5a5);
        send_op(OP_READ, 0, 32'h0);
        send_op(OP_READ, 5, 32'h0);
        send_op(OP_READ, 6, 32'h0);
        send_op(OP_READ, -1, 32'h0);
        send_op(OP_READ, 32767, 32'h0);
        send_op(OP_BAD_LO, 1, 32'h0bad_0005);
        send_op(OP_BAD_MID, -2, 32'h0bad_0006);
        send_op(OP_BAD_HI, 0, 32'h0bad_0007);
        send_op(OP_DELETE, -1, 32'h0);
        send_op(OP_DELETE, 6, 32'h0);
        send_op(OP_DELETE, 5, 32'h0);
        send_op(OP_DELETE, 0, 32'h0);
        send_op(OP_DELETE, 1, 32'h0);
        send_op(OP_READ, 1, 32'h0);

        phase = MIXED_PHASE;
        phase_left = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (phase_left == 0)
            begin
                case ($urandom_range(0, 2))
                    0: phase = FILL_PHASE;
                    1: phase = DRAIN_PHASE;
                    default: phase = MIXED_PHASE;
                endcase
                phase_left = $urandom_range(40, 150);
            end
            phase_left--;
            send_item(random_request(phase, tracker.count));
        end

        @(negedge clk);
        req_valid = 1'b0;
        while (tracker.expected_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/ilid_pkg.sv
rtl/ilid_ram.sv
rtl/ilid_datapath.sv
rtl/ilid_controller.sv
rtl/indexed_list_insert_delete.sv
tb/sv/tb.sv
